>>> hdl/dhd_pkg.sv
// ----------------------------------------------------------------------------
// Dip hit detector package
// Shared constants, register indexes and control types for the detector.
// ----------------------------------------------------------------------------
package dhd_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int POSITION_BITS = 11;

	localparam int REG_W = 5;
	localparam logic [REG_W-1:0] MIN_SAMPLES_RESET = 5'd8;
	localparam logic [REG_W-1:0] MAX_SAMPLES_RESET = 5'd15;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SAMPLES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAMPLES = 1'b1;

	localparam int HELD_W = 5;
	localparam int OUT_DATA_W = 8;

	// count / 3 as (count * 171) >> 9, exact for counts below 512
	localparam int DIV3_MUL = 171;
	localparam int DIV3_MUL_W = 8;
	localparam int DIV3_SHIFT = 9;

	localparam logic [1:0] PART_FIRST = 2'd0;
	localparam logic [1:0] PART_MID = 2'd1;
	localparam logic [1:0] PART_LAST = 2'd2;

	typedef struct packed {
		logic clr;
		logic add;
		logic [1:0] sel;
	} sum_ctrl_t;

endpackage

>>> hdl/dhd_hist_mem.sv
// ----------------------------------------------------------------------------
// Dip hit detector history memory
// Circular sample store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dhd_hist_mem #(
	parameter int DEPTH = dhd_pkg::HISTORY_DEPTH,
	parameter int POS_W = dhd_pkg::POSITION_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [POS_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [POS_W-1:0]         rdata
);
	import dhd_pkg::*;

	logic [POS_W-1:0] mem [DEPTH];
	logic [POS_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dhd_sum_unit.sv
// ----------------------------------------------------------------------------
// Dip hit detector sum unit
// One shared adder accumulating the three partition sums, plus the dip test.
// ----------------------------------------------------------------------------
module dhd_sum_unit #(
	parameter int DEPTH = dhd_pkg::HISTORY_DEPTH,
	parameter int POS_W = dhd_pkg::POSITION_BITS
) (
	input  logic                clk,
	input  dhd_pkg::sum_ctrl_t  ctrl,
	input  logic [POS_W-1:0]    data,
	output logic                dip
);
	import dhd_pkg::*;

	localparam int SUM_W = POS_W + $clog2(DEPTH);

	logic [SUM_W-1:0] first_q;
	logic [SUM_W-1:0] mid_q;
	logic [SUM_W-1:0] last_q;
	logic [SUM_W-1:0] operand;
	logic [SUM_W-1:0] result;

	always_comb begin
		case (ctrl.sel)
			PART_FIRST: operand = first_q;
			PART_MID:   operand = mid_q;
			default:    operand = last_q;
		endcase
	end

	assign result = operand + SUM_W'(data);

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			first_q <= '0;
			mid_q   <= '0;
			last_q  <= '0;
		end else if (ctrl.add) begin
			case (ctrl.sel)
				PART_FIRST: first_q <= result;
				PART_MID:   mid_q   <= result;
				default:    last_q  <= result;
			endcase
		end
	end

	assign dip = (last_q > mid_q) && (first_q > mid_q);

endmodule

>>> hdl/window_dip_hit_detector.sv
// ----------------------------------------------------------------------------
// Window dip hit detector
// Keeps a short history of tracked positions and reports a dip per sample.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per video frame, position in s_tdata.
// Output stream m_*: one result per request, hit flag and samples held.
// Configuration: cfg_we writes min_samples (index 0) or max_samples
// (index 1) from cfg_data; write only while no request is in flight.
// A request is taken only when the block is idle; it then stores the
// sample, drops the oldest one if more than max_samples are held, splits
// the held samples (count, up to HISTORY_DEPTH after trimming) into three
// parts, sums them through the single memory read port and the shared
// adder, compares, and holds the result in the output register. Below
// min_samples an item goes from storing straight to the output register.
// While m_tready is low the result is held and s_tready stays low.
// Reset empties the history and loads min_samples = 8, max_samples = 15.
// ----------------------------------------------------------------------------
module window_dip_hit_detector #(
	parameter int HISTORY_DEPTH = dhd_pkg::HISTORY_DEPTH,
	parameter int POSITION_BITS = dhd_pkg::POSITION_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((POSITION_BITS+7)/8)*8-1:0]    s_tdata,  // position
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [dhd_pkg::OUT_DATA_W-1:0]        m_tdata,  // hit, samples_held
	input  logic                                  cfg_we,
	input  logic [dhd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [dhd_pkg::REG_W-1:0]             cfg_data
);
	import dhd_pkg::*;

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
	localparam int PROD_W = CNT_W + DIV3_MUL_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]         state_q;
	logic [REG_W-1:0]   min_q;
	logic [REG_W-1:0]   max_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   part_q;
	logic [CNT_W-1:0]   part2_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic               hit_q;
	logic               rd_valid_s1;
	logic [1:0]         sel_s1;

	logic               accept;
	logic               full;
	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   head_ins;
	logic [CNT_W-1:0]   count_ins;
	logic [CNT_W:0]     waddr_sum;
	logic [PTR_W-1:0]   waddr;
	logic [CNT_W:0]     drop_sum;
	logic [PTR_W-1:0]   head_drop;
	logic [PTR_W-1:0]   rd_ptr_inc;
	logic [PROD_W-1:0]  div_prod;
	logic [CNT_W-1:0]   part_d;
	logic               issue;
	logic [1:0]         sel_d;
	logic [POSITION_BITS-1:0] rdata;
	logic               dip;
	sum_ctrl_t          sum_ctrl;

	assign accept = s_tvalid && s_tready;
	assign full = (count_q == CNT_W'(HISTORY_DEPTH));
	assign head_inc = (head_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_ins = full ? head_inc : head_q;
	assign count_ins = full ? count_q - 1'b1 : count_q;

	always_comb begin
		waddr_sum = (CNT_W+1)'(head_ins) + (CNT_W+1)'(count_ins);
		if (waddr_sum >= (CNT_W+1)'(HISTORY_DEPTH)) begin
			waddr_sum = waddr_sum - (CNT_W+1)'(HISTORY_DEPTH);
		end
		drop_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(part2_q);
		if (drop_sum >= (CNT_W+1)'(HISTORY_DEPTH)) begin
			drop_sum = drop_sum - (CNT_W+1)'(HISTORY_DEPTH);
		end
	end

	assign waddr = PTR_W'(waddr_sum);
	assign head_drop = PTR_W'(drop_sum);
	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign div_prod = PROD_W'(count_q) * PROD_W'(DIV3_MUL);
	assign part_d = CNT_W'(div_prod >> DIV3_SHIFT);

	assign issue = (state_q == S_SUM) && (rd_cnt_q != count_q);

	always_comb begin
		if (rd_cnt_q < part_q) begin
			sel_d = PART_FIRST;
		end else if (rd_cnt_q < part2_q) begin
			sel_d = PART_MID;
		end else begin
			sel_d = PART_LAST;
		end
	end

	assign sum_ctrl.clr = (state_q == S_DIV);
	assign sum_ctrl.add = rd_valid_s1;
	assign sum_ctrl.sel = sel_s1;

	dhd_hist_mem #(
		.DEPTH(HISTORY_DEPTH),
		.POS_W(POSITION_BITS)
	) u_mem (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (s_tdata[POSITION_BITS-1:0]),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	dhd_sum_unit #(
		.DEPTH(HISTORY_DEPTH),
		.POS_W(POSITION_BITS)
	) u_sum (
		.clk  (clk),
		.ctrl (sum_ctrl),
		.data (rdata),
		.dip  (dip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_SAMPLES_RESET;
			max_q <= MAX_SAMPLES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_SAMPLES: min_q <= cfg_data;
				REG_MAX_SAMPLES: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			part_q      <= '0;
			part2_q     <= '0;
			rd_cnt_q    <= '0;
			rd_ptr_q    <= '0;
			hit_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			sel_s1      <= PART_FIRST;
		end else begin
			rd_valid_s1 <= issue;
			sel_s1      <= sel_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q  <= head_ins;
						count_q <= count_ins + 1'b1;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (CMP_W'(count_q) >= CMP_W'(min_q)) begin
						if (CMP_W'(count_q) > CMP_W'(max_q)) begin
							head_q  <= head_inc;
							count_q <= count_q - 1'b1;
						end
						state_q <= S_DIV;
					end else begin
						hit_q   <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					part_q   <= part_d;
					part2_q  <= CNT_W'({part_d, 1'b0});
					rd_cnt_q <= '0;
					rd_ptr_q <= head_q;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
						rd_ptr_q <= rd_ptr_inc;
					end else if (!rd_valid_s1) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					hit_q <= dip;
					if (dip) begin
						head_q  <= head_drop;
						count_q <= count_q - part2_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = OUT_DATA_W'({HELD_W'(count_q), hit_q});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PTR_W'(HISTORY_DEPTH - 1))
		else $error("head pointer out of range");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q != '0) && (state_q == S_EVAL))
		else $error("stored sample not counted");

	a_read_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SUM))
		else $error("memory read outside summing");

	a_dip_needs_part: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) && dip |-> (part_q != '0) && (part2_q <= count_q))
		else $error("dip reported with empty partition");

endmodule

>>> bench/window_dip_hit_detector_tb.sv
// ----------------------------------------------------------------------------
// Window dip hit detector testbench
// Streams tracked positions through the detector under random source gaps and
// sink stalls, across several min/max sample settings including out-of-range
// register values. A scoreboard keeps its own position history, predicts the
// hit flag and held count for every accepted request and checks each result
// in order.
// ----------------------------------------------------------------------------
module window_dip_hit_detector_tb;
	import dhd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 110;
	localparam int IN_DATA_W = ((POSITION_BITS + 7) / 8) * 8;

	typedef logic [POSITION_BITS-1:0] position_t;
	typedef logic [REG_W-1:0] reg_t;
	typedef logic [HELD_W-1:0] held_t;

	typedef struct {
		logic hit;
		held_t held;
	} dip_verdict_t;

	class dip_scoreboard;
		position_t history[HISTORY_DEPTH];
		int held_count;
		reg_t min_samples;
		reg_t max_samples;
		dip_verdict_t pending_verdicts[$];
		int results_seen;
		int errors;

		function new();
			held_count = 0;
			min_samples = MIN_SAMPLES_RESET;
			max_samples = MAX_SAMPLES_RESET;
			results_seen = 0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] index, reg_t value);
			if (index == REG_MIN_SAMPLES) begin
				min_samples = value;
			end else if (index == REG_MAX_SAMPLES) begin
				max_samples = value;
			end
		endfunction

		function void discard_oldest(int n);
			int k;
			if (n > held_count) begin
				n = held_count;
			end
			for (k = 0; k + n < held_count; k++) begin
				history[k] = history[k + n];
			end
			held_count -= n;
		endfunction

		function void note_request(position_t pos);
			dip_verdict_t v;
			int unsigned first_sum;
			int unsigned mid_sum;
			int unsigned last_sum;
			int part;
			int k;
			first_sum = 0;
			mid_sum = 0;
			last_sum = 0;
			v.hit = 1'b0;
			if (held_count >= HISTORY_DEPTH) begin
				discard_oldest(1);
			end
			history[held_count] = pos;
			held_count++;
			if (held_count >= int'(min_samples)) begin
				if (held_count > int'(max_samples)) begin
					discard_oldest(1);
				end
				part = held_count / 3;
				for (k = 0; k < held_count; k++) begin
					if (k < part) begin
						first_sum += history[k];
					end else if (k < 2 * part) begin
						mid_sum += history[k];
					end else begin
						last_sum += history[k];
					end
				end
				if (last_sum > mid_sum && first_sum > mid_sum) begin
					discard_oldest(2 * part);
					v.hit = 1'b1;
				end
			end
			v.held = held_t'(held_count);
			pending_verdicts = {pending_verdicts, v};
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH on result %0d: %s", results_seen, what);
			errors++;
		endtask

		task check_result(logic hit, held_t held);
			dip_verdict_t v;
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result hit=%0d held=%0d", hit, held));
			end else begin
				v = pending_verdicts.pop_front();
				if (hit !== v.hit) begin
					report_mismatch($sformatf("hit %0d, want %0d", hit, v.hit));
				end
				if (held !== v.held) begin
					report_mismatch($sformatf("samples_held %0d, want %0d", held, v.held));
				end
			end
		endtask

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	reg_t cfg_data = '0;

	dip_scoreboard sb = new();
	int burst_left = 0;
	int cycle_count = 0;

	window_dip_hit_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[0], m_tdata[HELD_W:1]);
		end
	end

	// sink stall pattern: free-running, then random, mostly ready, mostly stalled
	initial begin
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: begin
						m_tready <= 1'b1;
					end
					1: begin
						m_tready <= $urandom_range(0, 1);
					end
					2: begin
						m_tready <= ($urandom_range(0, 7) != 0);
					end
					default: begin
						m_tready <= ($urandom_range(0, 9) == 0);
					end
				endcase
			end
		end
	end

	task send_position(position_t pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(pos);
		do @(posedge clk); while (!s_tready);
		sb.note_request(pos);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task set_limits(reg_t min_value, reg_t max_value);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_SAMPLES;
		cfg_data <= min_value;
		@(posedge clk);
		cfg_index <= REG_MAX_SAMPLES;
		cfg_data <= max_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(REG_MIN_SAMPLES, min_value);
		sb.set_register(REG_MAX_SAMPLES, max_value);
	endtask

	function position_t pick_level(bit high_side);
		if ($urandom_range(0, 9) == 0) begin
			return high_side ? position_t'(2047) : position_t'(0);
		end
		return high_side ? position_t'($urandom_range(1200, 2047))
			: position_t'($urandom_range(0, 900));
	endfunction

	// dips with random run lengths dominate; noise, ramps and flat runs break them
	task feed_shapes(int count);
		int sent;
		int shape;
		int run;
		int k;
		int seg;
		position_t base;
		sent = 0;
		while (sent < count) begin
			shape = $urandom_range(0, 9);
			if (shape < 6) begin
				run = $urandom_range(1, 6);
				for (seg = 0; seg < 3; seg++) begin
					for (k = 0; k < run; k++) begin
						send_position(pick_level(seg != 1));
						sent++;
					end
				end
			end else if (shape < 8) begin
				run = $urandom_range(1, 8);
				for (k = 0; k < run; k++) begin
					send_position(position_t'($urandom_range(0, 2047)));
					sent++;
				end
			end else if (shape == 8) begin
				run = $urandom_range(4, 18);
				base = position_t'($urandom_range(0, 1000));
				for (k = 0; k < run; k++) begin
					send_position(base + position_t'(k * 50));
					sent++;
				end
			end else begin
				run = $urandom_range(3, 12);
				base = position_t'($urandom_range(0, 2047));
				for (k = 0; k < run; k++) begin
					send_position(base);
					sent++;
				end
			end
		end
	endtask

	initial begin
		int k;
		int phase;
		reg_t min_value;
		reg_t max_value;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: below minimum, no evaluation
		send_position(position_t'(0));
		send_position(position_t'(2047));
		send_position(position_t'(1));
		drain();

		// smallest window: a three-sample dip hits
		set_limits(5'd3, 5'd3);
		send_position(position_t'(2047));
		send_position(position_t'(0));
		send_position(position_t'(2047));
		drain();

		// zero maximum drops the oldest sample each step, so one sample stays held
		set_limits(5'd0, 5'd0);
		send_position(position_t'(5));
		send_position(position_t'(7));
		drain();

		// tiny counts: partition of zero never hits
		set_limits(5'd1, 5'd2);
		send_position(position_t'(9));
		send_position(position_t'(3));
		drain();

		// minimum above maximum and above depth: history fills and overflows
		set_limits(5'd31, 5'd16);
		for (k = 0; k < 15; k++) begin
			send_position(position_t'(k * 136));
		end
		drain();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					min_value = 5'd3;
					max_value = 5'd16;
				end
				1: begin
					min_value = 5'd16;
					max_value = 5'd16;
				end
				2: begin
					min_value = 5'd3;
					max_value = 5'd31;
				end
				3: begin
					min_value = 5'd16;
					max_value = 5'd3;
				end
				4: begin
					min_value = 5'd0;
					max_value = 5'd9;
				end
				5: begin
					min_value = 5'd8;
					max_value = 5'd15;
				end
				default: begin
					min_value = ($urandom_range(0, 3) == 0) ? reg_t'($urandom_range(0, 31))
						: reg_t'($urandom_range(3, 16));
					max_value = ($urandom_range(0, 3) == 0) ? reg_t'($urandom_range(0, 31))
						: reg_t'($urandom_range(3, 16));
				end
			endcase
			set_limits(min_value, max_value);
			feed_shapes(PHASE_ITEMS);
			drain();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/dhd_pkg.sv
hdl/dhd_hist_mem.sv
hdl/dhd_sum_unit.sv
hdl/window_dip_hit_detector.sv
bench/window_dip_hit_detector_tb.sv
